// ===== hw/rtl/mcfc_pkg.sv =====
// Shared types, codes and constants of the motor CAN feedback/command block.
`default_nettype none
package mcfc_pkg;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int ID_W       = 11;
  localparam int DATA_W     = 64;
  localparam int CUR_W      = 16;
  localparam int ENC_W      = 13;
  localparam int TOTAL_W    = 32;
  localparam int TEMP_W     = 8;
  localparam int COUNT_W    = 32;
  localparam int MS_W       = 16;
  localparam int LIMIT_W    = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Encoder wrap constants
  localparam int ENC_MOD  = 8192;
  localparam int ENC_HALF = 4096;

  // Saturation value of the ms counters
  localparam logic [MS_W-1:0] MS_MAX = '1;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [LIMIT_W-1:0] RST_CURRENT_LIMIT = 15'd10000;
  localparam logic [MS_W-1:0]    RST_OFFLINE_MS    = 16'd100;
  localparam logic [MS_W-1:0]    RST_COMMAND_MS    = 16'd100;
  localparam logic [ID_W-1:0]    RST_FEEDBACK_ID   = 11'd513;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURRENT_LIMIT = 2'd0,
    CFG_OFFLINE_MS    = 2'd1,
    CFG_COMMAND_MS    = 2'd2,
    CFG_FEEDBACK_ID   = 2'd3
  } cfg_idx_t;

  // Input command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_FEEDBACK = 2'd1,
    CMD_SET      = 2'd2,
    CMD_FRICTION = 2'd3
  } cmd_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_TICK     = 3'd1,
    OP_FEEDBACK = 3'd2,
    OP_SET      = 3'd3,
    OP_FRICTION = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [ENC_W-1:0]   enc;
    logic [CUR_W-1:0]   speed;
    logic [CUR_W-1:0]   cur;
    logic [TEMP_W-1:0]  temp;
    logic [CUR_W-1:0]   cur_a;
    logic [CUR_W-1:0]   cur_b;
  } op_t;

  // Configuration register set
  typedef struct packed {
    logic [LIMIT_W-1:0] current_limit;
    logic [MS_W-1:0]    offline_ms;
    logic [MS_W-1:0]    command_ms;
    logic [ID_W-1:0]    feedback_id;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mcfc_if.sv =====
// Valid/ready channel interfaces for input words and result words.
`default_nettype none
interface mcfc_in_if;
  import mcfc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [ID_W-1:0]     can_id;
  logic [DATA_W-1:0]   frame_data;
  logic signed [CUR_W-1:0] current_a;
  logic signed [CUR_W-1:0] current_b;

  modport source (output valid, command, can_id, frame_data, current_a, current_b,
                  input ready);
  modport sink   (input valid, command, can_id, frame_data, current_a, current_b,
                  output ready);
endinterface

interface mcfc_out_if;
  import mcfc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      tx_valid;
  logic [DATA_W-1:0]         tx_payload;
  logic [ENC_W-1:0]          encoder_position;
  logic signed [TOTAL_W-1:0] enc_accum;
  logic signed [CUR_W-1:0]   rotor_speed;
  logic signed [CUR_W-1:0]   motor_current;
  logic [TEMP_W-1:0]         temperature;
  logic                      online;
  logic [COUNT_W-1:0]        fb_frames;

  modport source (output valid, tx_valid, tx_payload, encoder_position, enc_accum,
                         rotor_speed, motor_current, temperature, online, fb_frames,
                  input ready);
  modport sink   (input valid, tx_valid, tx_payload, encoder_position, enc_accum,
                        rotor_speed, motor_current, temperature, online, fb_frames,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/motor_can_feedback_command_top.sv =====
// Top level of the motor CAN feedback decoder and current-group command block.
//
// Usage: in_chan carries one event word per handshake (ms tick, received
// feedback frame, set-current or friction-pair command); out_chan returns
// exactly one result word per input word, in order: the command frame (when
// tx_valid is set) and the motor status after that event. The cfg port writes
// the four registers (current limit, offline and command timeouts, feedback
// id); the user must use it only while the block is idle, which the block
// itself does not enforce. An accepted word is written into the queue, then
// popped by the back end, which loads the result register. Throughput: one
// word per cycle while the receiver takes the results.
// Reset (synchronous, rst_n low) clears all motor state, timers and the
// current group and loads the register defaults.
// When the receiver stalls, the result is held; the two-entry queue between
// front and back then fills and in_chan.ready drops once both entries are taken.
`default_nettype none
module motor_can_feedback_command_top
  import mcfc_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mcfc_in_if.sink               in_chan,
  mcfc_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic push_valid, push_ready;
  op_t  push_op;
  logic pop_valid, pop_ready;
  op_t  pop_op;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_limit <= RST_CURRENT_LIMIT;
      cfg_r.offline_ms    <= RST_OFFLINE_MS;
      cfg_r.command_ms    <= RST_COMMAND_MS;
      cfg_r.feedback_id   <= RST_FEEDBACK_ID;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CURRENT_LIMIT: cfg_r.current_limit <= cfg_wdata[LIMIT_W-1:0];
        CFG_OFFLINE_MS:    cfg_r.offline_ms    <= cfg_wdata[MS_W-1:0];
        CFG_COMMAND_MS:    cfg_r.command_ms    <= cfg_wdata[MS_W-1:0];
        CFG_FEEDBACK_ID:   cfg_r.feedback_id   <= cfg_wdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  mcfc_front u_front (
    .in_chan    (in_chan),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  mcfc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  mcfc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .op_valid (pop_valid),
    .op_ready (pop_ready),
    .op       (pop_op),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/mcfc_front.sv =====
// Front end: accepts input words, filters feedback frames, clamps set-current.
`default_nettype none
module mcfc_front
  import mcfc_pkg::*;
(
  mcfc_in_if.sink    in_chan,
  input  cfg_t       cfg,
  output logic       push_valid,
  input  logic       push_ready,
  output op_t        push_op
);

  logic [CUR_W-1:0]        enc_word;
  logic                    fb_ok;
  logic signed [CUR_W-1:0] lim;
  logic signed [CUR_W-1:0] neg_lim;
  logic signed [CUR_W-1:0] clamped;

  assign in_chan.ready = push_ready;
  assign push_valid    = in_chan.valid;

  // Feedback filter: id match and encoder word in range
  assign enc_word = in_chan.frame_data[63:48];
  assign fb_ok    = (in_chan.can_id == cfg.feedback_id) &&
                    (enc_word < CUR_W'(ENC_MOD));

  // Symmetric clamp of the set-current request
  assign lim     = signed'({1'b0, cfg.current_limit});
  assign neg_lim = -lim;
  always_comb begin
    clamped = in_chan.current_a;
    if (in_chan.current_a > lim) clamped = lim;
    if (in_chan.current_a < neg_lim) clamped = neg_lim;
  end

  // Classify the word into a back-end operation
  always_comb begin
    push_op       = '0;
    push_op.enc   = enc_word[ENC_W-1:0];
    push_op.speed = in_chan.frame_data[47:32];
    push_op.cur   = in_chan.frame_data[31:16];
    push_op.temp  = in_chan.frame_data[15:8];
    push_op.cur_a = in_chan.current_a;
    push_op.cur_b = in_chan.current_b;
    unique case (cmd_t'(in_chan.command))
      CMD_TICK:     push_op.kind = OP_TICK;
      CMD_FEEDBACK: push_op.kind = fb_ok ? OP_FEEDBACK : OP_NOP;
      CMD_SET: begin
        push_op.kind  = OP_SET;
        push_op.cur_a = clamped;
      end
      CMD_FRICTION: push_op.kind = OP_FRICTION;
      default:      push_op.kind = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mcfc_queue.sv =====
// Short register FIFO of classified operations between front and back.
`default_nettype none
module mcfc_queue
  import mcfc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_op
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              mem_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r;
  logic [IDX_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_op;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mcfc_back.sv =====
// Back end: motor state update, timers, current group and result register.
`default_nettype none
module mcfc_back
  import mcfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        op_valid,
  output logic        op_ready,
  input  op_t         op,
  mcfc_out_if.source  out_chan
);

  // Motor state
  logic [CUR_W-1:0]   slot_r [4];
  logic [CUR_W-1:0]   slot_nxt [4];
  logic [ENC_W-1:0]   last_pos_r, last_pos_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [CUR_W-1:0]   speed_r, speed_nxt;
  logic [CUR_W-1:0]   fb_cur_r, fb_cur_nxt;
  logic [TEMP_W-1:0]  temp_r, temp_nxt;
  logic [COUNT_W-1:0] frame_count_r, frame_count_nxt;
  logic               seen_r, seen_nxt;
  logic               online_r, online_nxt;
  logic [MS_W-1:0]    ms_rx_r, ms_rx_nxt;
  logic [MS_W-1:0]    ms_cmd_r, ms_cmd_nxt;
  logic               active_r, active_nxt;
  logic               tx_nxt;

  // Result register
  logic               out_valid_r;
  logic               tx_valid_r;
  logic [DATA_W-1:0]  tx_payload_r;
  logic [ENC_W-1:0]   pos_out_r;
  logic [TOTAL_W-1:0] total_out_r;
  logic [CUR_W-1:0]   speed_out_r;
  logic [CUR_W-1:0]   cur_out_r;
  logic [TEMP_W-1:0]  temp_out_r;
  logic               online_out_r;
  logic [COUNT_W-1:0] count_out_r;

  logic               pop;
  logic [MS_W-1:0]    ms_rx_inc;
  logic [MS_W-1:0]    ms_cmd_inc;
  logic signed [ENC_W:0] delta_raw;
  logic signed [ENC_W:0] delta;

  // Take the next operation when the result register is free or draining
  assign op_ready = !out_valid_r || out_chan.ready;
  assign pop      = op_valid && op_ready;

  // Saturating ms counters
  assign ms_rx_inc  = (ms_rx_r == MS_MAX) ? ms_rx_r : ms_rx_r + 1'b1;
  assign ms_cmd_inc = (ms_cmd_r == MS_MAX) ? ms_cmd_r : ms_cmd_r + 1'b1;

  // Half-turn unwrap of the encoder step
  assign delta_raw = signed'({1'b0, op.enc}) - signed'({1'b0, last_pos_r});
  always_comb begin
    delta = delta_raw;
    if (delta_raw > (ENC_W+1)'(ENC_HALF))       delta = delta_raw - (ENC_W+1)'(ENC_MOD);
    else if (delta_raw < -(ENC_W+1)'(ENC_HALF)) delta = delta_raw + (ENC_W+1)'(ENC_MOD);
  end

  // Next state for one operation
  always_comb begin
    slot_nxt        = slot_r;
    last_pos_nxt    = last_pos_r;
    total_nxt       = total_r;
    speed_nxt       = speed_r;
    fb_cur_nxt      = fb_cur_r;
    temp_nxt        = temp_r;
    frame_count_nxt = frame_count_r;
    seen_nxt        = seen_r;
    online_nxt      = online_r;
    ms_rx_nxt       = ms_rx_r;
    ms_cmd_nxt      = ms_cmd_r;
    active_nxt      = active_r;
    tx_nxt          = 1'b0;
    unique case (op.kind)
      OP_TICK: begin
        ms_rx_nxt  = ms_rx_inc;
        ms_cmd_nxt = ms_cmd_inc;
        online_nxt = seen_r && (ms_rx_inc < cfg.offline_ms);
        // command timeout forces the current back to zero
        if (active_r && (ms_cmd_inc >= cfg.command_ms)) begin
          slot_nxt[3] = '0;
          active_nxt  = 1'b0;
          ms_cmd_nxt  = '0;
          tx_nxt      = 1'b1;
        end
      end
      OP_FEEDBACK: begin
        if (seen_r) total_nxt = total_r + TOTAL_W'(delta);
        last_pos_nxt    = op.enc;
        speed_nxt       = op.speed;
        fb_cur_nxt      = op.cur;
        temp_nxt        = op.temp;
        ms_rx_nxt       = '0;
        frame_count_nxt = frame_count_r + 1'b1;
        seen_nxt        = 1'b1;
        online_nxt      = 1'b1;
      end
      OP_SET: begin
        slot_nxt[3] = op.cur_a;
        ms_cmd_nxt  = '0;
        active_nxt  = (op.cur_a != '0);
        tx_nxt      = 1'b1;
      end
      OP_FRICTION: begin
        slot_nxt[0] = op.cur_a;
        slot_nxt[1] = op.cur_b;
        tx_nxt      = 1'b1;
      end
      OP_NOP: ;
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) slot_r[i] <= '0;
      last_pos_r    <= '0;
      total_r       <= '0;
      speed_r       <= '0;
      fb_cur_r      <= '0;
      temp_r        <= '0;
      frame_count_r <= '0;
      seen_r        <= 1'b0;
      online_r      <= 1'b0;
      ms_rx_r       <= '0;
      ms_cmd_r      <= '0;
      active_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (pop) begin
        slot_r        <= slot_nxt;
        last_pos_r    <= last_pos_nxt;
        total_r       <= total_nxt;
        speed_r       <= speed_nxt;
        fb_cur_r      <= fb_cur_nxt;
        temp_r        <= temp_nxt;
        frame_count_r <= frame_count_nxt;
        seen_r        <= seen_nxt;
        online_r      <= online_nxt;
        ms_rx_r       <= ms_rx_nxt;
        ms_cmd_r      <= ms_cmd_nxt;
        active_r      <= active_nxt;
      end
      if (pop)                  out_valid_r <= 1'b1;
      else if (out_chan.ready)  out_valid_r <= 1'b0;
    end
  end

  // Result word, loaded with the state after the operation
  always_ff @(posedge clk) begin
    if (pop) begin
      tx_valid_r   <= tx_nxt;
      tx_payload_r <= tx_nxt ? {slot_nxt[0], slot_nxt[1], slot_nxt[2], slot_nxt[3]} : '0;
      pos_out_r    <= last_pos_nxt;
      total_out_r  <= total_nxt;
      speed_out_r  <= speed_nxt;
      cur_out_r    <= fb_cur_nxt;
      temp_out_r   <= temp_nxt;
      online_out_r <= online_nxt;
      count_out_r  <= frame_count_nxt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.tx_valid         = tx_valid_r;
  assign out_chan.tx_payload       = tx_payload_r;
  assign out_chan.encoder_position = pos_out_r;
  assign out_chan.enc_accum        = signed'(total_out_r);
  assign out_chan.rotor_speed      = signed'(speed_out_r);
  assign out_chan.motor_current    = signed'(cur_out_r);
  assign out_chan.temperature      = temp_out_r;
  assign out_chan.online           = online_out_r;
  assign out_chan.fb_frames        = count_out_r;

`ifndef SYNTHESIS
  // Online is only possible after a first accepted frame
  a_online_seen: assert property (@(posedge clk) disable iff (!rst_n)
    online_r |-> seen_r) else $error("online without any feedback");

  // An active command always holds a nonzero slot 3 current
  a_active_slot: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (slot_r[3] != '0)) else $error("active command with zero current");

  // Every accepted feedback frame bumps the frame counter by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && op.kind == OP_FEEDBACK) |=> (frame_count_r == $past(frame_count_r) + 32'd1))
    else $error("frame counter did not advance");

  // A result without a command frame carries an empty payload
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !tx_valid_r) |-> (tx_payload_r == '0))
    else $error("payload set without tx_valid");
`endif

endmodule
`default_nettype wire
